// ===== sv/skt_pkg.sv =====
// Shared types and codes for the sorted key table.
package skt_pkg;

    typedef enum logic [1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_MISS  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic    found;
        status_t status;
    } result_t;

endpackage

// ===== sv/skt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/skt_seq.sv =====
// Scan sequencer: walks the key RAM one entry a cycle, shifting on insert and delete.
module skt_seq #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           start_op,
    input  logic [KEY_BITS-1:0]  start_key,
    output logic                 busy,
    output logic                 res_valid,
    input  logic                 res_take,
    output skt_pkg::result_t     res,
    output logic [CW-1:0]        count,
    output logic                 ram_we,
    output logic [AW-1:0]        ram_waddr,
    output logic [KEY_BITS-1:0]  ram_wdata,
    output logic [AW-1:0]        ram_raddr,
    input  logic [KEY_BITS-1:0]  ram_rdata
);

    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    skt_pkg::seq_state_t state_reg, state_next;
    skt_pkg::opcode_t    op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] carry_reg, carry_next;
    logic [CW-1:0]       cur_reg, cur_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                shift_reg, shift_next;
    skt_pkg::result_t    res_reg, res_next;

    logic [CW-1:0] cur_inc;
    logic [CW-1:0] cur_dec;
    logic          at_end;
    logic          last;
    logic          eq;
    logic          gt;
    logic          lt;

    assign cur_inc = cur_reg + CW'(1);
    assign cur_dec = cur_reg - CW'(1);
    assign at_end  = (cur_reg == count_reg);
    assign last    = (cur_inc == count_reg);
    assign eq      = (ram_rdata == key_reg);
    assign gt      = (ram_rdata > key_reg);
    assign lt      = (ram_rdata < key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skt_pkg::SEQ_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        carry_reg <= carry_next;
        cur_reg   <= cur_next;
        shift_reg <= shift_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        carry_next = carry_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg[AW-1:0];
        ram_wdata  = key_reg;
        ram_raddr  = cur_inc[AW-1:0];

        case (state_reg)
            skt_pkg::SEQ_IDLE:
            begin
                ram_raddr = '0;
                if (start)
                begin
                    op_next         = skt_pkg::opcode_t'(start_op);
                    key_next        = start_key;
                    cur_next        = '0;
                    shift_next      = 1'b0;
                    res_next.found  = 1'b0;
                    res_next.status = skt_pkg::STAT_OK;
                    case (skt_pkg::opcode_t'(start_op))
                        skt_pkg::OP_SEARCH, skt_pkg::OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = skt_pkg::STAT_EMPTY;
                                state_next      = skt_pkg::SEQ_DONE;
                            end
                            else
                            begin
                                state_next = skt_pkg::SEQ_SCAN;
                            end
                        end
                        skt_pkg::OP_INSERT:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                res_next.status = skt_pkg::STAT_FULL;
                                state_next      = skt_pkg::SEQ_DONE;
                            end
                            else
                            begin
                                state_next = skt_pkg::SEQ_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = skt_pkg::SEQ_DONE;
                        end
                    endcase
                end
            end

            skt_pkg::SEQ_SCAN:
            begin
                case (op_reg)
                    skt_pkg::OP_SEARCH:
                    begin
                        if (at_end || gt)
                        begin
                            res_next.status = skt_pkg::STAT_MISS;
                            state_next      = skt_pkg::SEQ_DONE;
                        end
                        else if (eq)
                        begin
                            res_next.found = 1'b1;
                            state_next     = skt_pkg::SEQ_DONE;
                        end
                        else
                        begin
                            cur_next = cur_inc;
                        end
                    end

                    skt_pkg::OP_DELETE:
                    begin
                        if (shift_reg)
                        begin
                            // move entry down over the gap
                            ram_we    = 1'b1;
                            ram_waddr = cur_dec[AW-1:0];
                            ram_wdata = ram_rdata;
                            if (last)
                            begin
                                count_next = count_reg - CW'(1);
                                state_next = skt_pkg::SEQ_DONE;
                            end
                            else
                            begin
                                cur_next = cur_inc;
                            end
                        end
                        else if (at_end || gt)
                        begin
                            res_next.status = skt_pkg::STAT_MISS;
                            state_next      = skt_pkg::SEQ_DONE;
                        end
                        else if (eq)
                        begin
                            res_next.found = 1'b1;
                            if (last)
                            begin
                                count_next = count_reg - CW'(1);
                                state_next = skt_pkg::SEQ_DONE;
                            end
                            else
                            begin
                                shift_next = 1'b1;
                                cur_next   = cur_inc;
                            end
                        end
                        else
                        begin
                            cur_next = cur_inc;
                        end
                    end

                    skt_pkg::OP_INSERT:
                    begin
                        if (shift_reg)
                        begin
                            // ripple the displaced key one place up
                            ram_we    = 1'b1;
                            ram_wdata = carry_reg;
                            if (at_end)
                            begin
                                count_next = count_reg + CW'(1);
                                state_next = skt_pkg::SEQ_DONE;
                            end
                            else
                            begin
                                carry_next = ram_rdata;
                                cur_next   = cur_inc;
                            end
                        end
                        else if (at_end)
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            state_next = skt_pkg::SEQ_DONE;
                        end
                        else if (!lt)
                        begin
                            ram_we     = 1'b1;
                            carry_next = ram_rdata;
                            shift_next = 1'b1;
                            cur_next   = cur_inc;
                        end
                        else
                        begin
                            cur_next = cur_inc;
                        end
                    end

                    default:
                    begin
                        state_next = skt_pkg::SEQ_DONE;
                    end
                endcase
            end

            skt_pkg::SEQ_DONE:
            begin
                if (res_take)
                begin
                    state_next = skt_pkg::SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = skt_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != skt_pkg::SEQ_IDLE);
    assign res_valid = (state_reg == skt_pkg::SEQ_DONE);
    assign res       = res_reg;
    assign count     = count_reg;

endmodule

// ===== sv/sorted_key_table_core.sv =====
// Sorted key table top level: key RAM, scan sequencer and output register.
// Searches and deletes scan from entry 0 until a hit, a larger key or the end; inserts scan
// and shift up to the end; a delete hit shifts the rest down; empty, full and unused-opcode
// words finish without a scan. One word at a time: the next is taken only after the last
// result has been taken, later under output stall; one RAM entry read per scan cycle.
// Reset clears the entry count and control; the key RAM is not cleared.
module sorted_key_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         opcode,
    input  logic [31:0]                        key,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [1:0]                         status,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]   entry_total
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [KEY_BITS-1:0] key_in;
    logic                start;
    logic                busy;
    logic                res_valid;
    logic                res_take;
    skt_pkg::result_t    res;
    logic [CW-1:0]       count;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    logic                out_valid_reg;
    logic                found_reg;
    skt_pkg::status_t    status_reg;
    logic [CW-1:0]       total_reg;

    generate
        if (KEY_BITS <= 32)
        begin : g_key_narrow
            assign key_in = key[KEY_BITS-1:0];
        end
        else
        begin : g_key_wide
            assign key_in = {{(KEY_BITS-32){1'b0}}, key};
        end
    endgenerate

    assign in_stall = busy;
    assign start    = in_valid && !busy;
    assign res_take = !out_valid_reg || !out_stall;

    skt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    skt_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .start_op  (opcode),
        .start_key (key_in),
        .busy      (busy),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .count     (count),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            found_reg  <= res.found;
            status_reg <= res.status;
            total_reg  <= count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign entry_total = total_reg;

endmodule

// ===== sim/tb_sorted_key_table_core.sv =====
// Self-checking testbench for the sorted key table: table predictor, scoreboard and drivers.
package skt_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KT_DEPTH = 64;
    localparam int KT_TOTAL_W = $clog2(KT_DEPTH + 1);
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic                  found;
        skt_pkg::status_t      status;
        logic [KT_TOTAL_W-1:0] total;
    } table_reply_t;

    class key_table_scoreboard;
        logic [31:0]  keys [KT_DEPTH];
        int unsigned  count;
        table_reply_t reply_queue [$];
        int unsigned  errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // First stored key that is not smaller than k.
        function int unsigned first_not_below(logic [31:0] k);
            int unsigned i;
            i = 0;
            while (i < count && keys[i] < k)
                i++;
            return i;
        endfunction

        // Applies an accepted word to the table copy and queues the reply it must give.
        function void apply_word(logic [1:0] op, logic [31:0] k);
            table_reply_t r;
            int unsigned  pos;
            r.found  = 1'b0;
            r.status = skt_pkg::STAT_OK;
            if (op == skt_pkg::OP_SEARCH || op == skt_pkg::OP_DELETE) begin
                if (count == 0) begin
                    r.status = skt_pkg::STAT_EMPTY;
                end else begin
                    pos = first_not_below(k);
                    if (pos < count && keys[pos] == k) begin
                        r.found = 1'b1;
                        if (op == skt_pkg::OP_DELETE) begin
                            for (int unsigned j = pos; j + 1 < count; j++)
                                keys[j] = keys[j + 1];
                            count--;
                        end
                    end else begin
                        r.status = skt_pkg::STAT_MISS;
                    end
                end
            end else if (op == skt_pkg::OP_INSERT) begin
                if (count >= KT_DEPTH) begin
                    r.status = skt_pkg::STAT_FULL;
                end else begin
                    pos = first_not_below(k);
                    for (int unsigned j = count; j > pos; j--)
                        keys[j] = keys[j - 1];
                    keys[pos] = k;
                    count++;
                end
            end
            r.total = KT_TOTAL_W'(count);
            reply_queue.push_back(r);
        endfunction

        function void check_reply(logic f, logic [1:0] st, logic [KT_TOTAL_W-1:0] tot);
            table_reply_t exp_r;
            if (reply_queue.size() == 0) begin
                $display("%0t: reply with none pending: found %0d status %0d total %0d",
                         $time, f, st, tot);
                errors++;
                return;
            end
            exp_r = reply_queue.pop_front();
            if (f !== exp_r.found) begin
                $display("%0t: found mismatch: expected %0d actual %0d",
                         $time, exp_r.found, f);
                errors++;
            end
            if (st !== exp_r.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, exp_r.status, st);
                errors++;
            end
            if (tot !== exp_r.total) begin
                $display("%0t: entry_total mismatch: expected %0d actual %0d",
                         $time, exp_r.total, tot);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return reply_queue.size();
        endfunction
    endclass
endpackage

module tb_sorted_key_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1750;
    localparam int CYCLE_LIMIT  = 1200000;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [1:0]                        opcode;
    logic [31:0]                       key;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic                              found;
    logic [1:0]                        status;
    logic [skt_tb_pkg::KT_TOTAL_W-1:0] entry_total;

    skt_tb_pkg::key_table_scoreboard sb;
    int unsigned                     burst_left;
    int unsigned                     cycle_count = 0;

    sorted_key_table_core #(
        .TABLE_DEPTH(skt_tb_pkg::KT_DEPTH),
        .KEY_BITS   (32)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .status     (status),
        .entry_total(entry_total)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: stall behaviour switches at random between none, coin toss and long runs.
    int unsigned stall_mode = 0;
    int unsigned stall_run = 0;
    always @(posedge clk)
    begin
        logic next_stall;
        if (out_valid && !out_stall)
            sb.check_reply(found, status, entry_total);
        if (cycle_count % 97 == 0)
            stall_mode = $urandom_range(0, 2);
        next_stall = 1'b0;
        if (stall_mode == 1)
            next_stall = 1'($urandom_range(0, 1));
        else if (stall_mode == 2)
        begin
            if (stall_run > 0)
            begin
                stall_run--;
                next_stall = 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
                stall_run = $urandom_range(1, 30);
        end
        out_stall <= next_stall;
    end

    task automatic send_word(input logic [1:0] op, input logic [31:0] k);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(20, 80)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        do
            @(posedge clk);
        while (in_stall);
        sb.apply_word(op, k);
    endtask

    // Keys for searches and deletes mostly come from the table so that hits are common.
    function automatic logic [31:0] pick_key(input logic [1:0] op);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (sb.count > 0 && ((op != skt_pkg::OP_INSERT && r < 6) || r < 2))
            return sb.keys[$urandom_range(0, sb.count - 1)];
        case ($urandom_range(0, 2))
            0: return 32'($urandom_range(0, 7));
            1:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'hFFFF_FFFE;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        traffic_mix_t mix;
        int unsigned  mix_left;
        int unsigned  r;
        logic [1:0]   op;

        sb          = new();
        burst_left  = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= skt_pkg::OP_SEARCH;
        key       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, edge keys, duplicates, front and back, unused opcode.
        send_word(skt_pkg::OP_SEARCH, 32'h0000_0000);
        send_word(skt_pkg::OP_DELETE, 32'hFFFF_FFFF);
        send_word(skt_tb_pkg::OP_UNUSED, 32'h0000_0000);
        send_word(skt_pkg::OP_INSERT, 32'h8000_0000);
        send_word(skt_pkg::OP_INSERT, 32'h0000_0000);
        send_word(skt_pkg::OP_INSERT, 32'hFFFF_FFFF);
        send_word(skt_pkg::OP_INSERT, 32'h8000_0000);
        send_word(skt_pkg::OP_INSERT, 32'h8000_0000);
        send_word(skt_pkg::OP_SEARCH, 32'h0000_0000);
        send_word(skt_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_word(skt_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        send_word(skt_pkg::OP_SEARCH, 32'h0000_0001);
        send_word(skt_pkg::OP_DELETE, 32'h8000_0000);
        send_word(skt_pkg::OP_DELETE, 32'h8000_0001);
        send_word(skt_pkg::OP_DELETE, 32'h0000_0000);
        send_word(skt_pkg::OP_SEARCH, 32'hFFFF_FFFE);
        send_word(skt_pkg::OP_DELETE, 32'hFFFF_FFFF);
        send_word(skt_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_word(skt_tb_pkg::OP_UNUSED, 32'hFFFF_FFFF);
        send_word(skt_pkg::OP_INSERT, 32'h5555_5555);
        send_word(skt_pkg::OP_INSERT, 32'hAAAA_AAAA);
        send_word(skt_pkg::OP_DELETE, 32'h8000_0000);
        send_word(skt_pkg::OP_DELETE, 32'h8000_0000);
        send_word(skt_pkg::OP_DELETE, 32'h5555_5555);
        send_word(skt_pkg::OP_DELETE, 32'hAAAA_AAAA);
        send_word(skt_pkg::OP_SEARCH, 32'hAAAA_AAAA);

        // Random: first mix fills the table so full inserts show up early.
        mix      = MIX_FILL;
        mix_left = 200;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (mix_left == 0)
            begin
                mix      = traffic_mix_t'($urandom_range(0, 2));
                mix_left = $urandom_range(40, 200);
            end
            mix_left--;
            r = $urandom_range(0, 99);
            if (r < 4)
                op = skt_tb_pkg::OP_UNUSED;
            else if (mix == MIX_FILL)
                op = (r < 80) ? skt_pkg::OP_INSERT
                   : (r < 90) ? skt_pkg::OP_SEARCH : skt_pkg::OP_DELETE;
            else if (mix == MIX_DRAIN)
                op = (r < 20) ? skt_pkg::OP_INSERT
                   : (r < 45) ? skt_pkg::OP_SEARCH : skt_pkg::OP_DELETE;
            else
                op = (r < 40) ? skt_pkg::OP_INSERT
                   : (r < 70) ? skt_pkg::OP_SEARCH : skt_pkg::OP_DELETE;
            send_word(op, pick_key(op));
        end
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (skt_tb_pkg::KT_DEPTH + 10) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
